[rtl/trie_prefix_conflict_checker_macros.svh]
// Assertion macros for the checker file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TRIE_PREFIX_CONFLICT_CHECKER_MACROS_SVH
`define TRIE_PREFIX_CONFLICT_CHECKER_MACROS_SVH

// Same-cycle implication.
`define TPCC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TPCC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tpcc_pkg.sv]
// Shared types and constants of the trie prefix conflict checker.
// No dependencies.
`default_nettype none

package tpcc_pkg;

	// Width of the digit field on the input port.
	localparam int DIGIT_W = 4;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_CLR  = 3'b100
	} state_t;

endpackage

`default_nettype wire

[rtl/tpcc_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module tpcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/trie_prefix_conflict_checker.sv]
// Trie prefix conflict checker: top level, sequencer and node-row memory.
// Depends on tpcc_pkg and tpcc_ram.
//
//  channel   handshake           fields
//  --------  ------------------  ----------------------------------------
//  input     start & !busy       digit[3:0], last_digit, new_list
//  result    done (one cycle)    list_conflict, pool_full, number_done
//
// Steps: a digit is a row read, then a modify and write back, since the node-row
// memory has a registered read. A last digit that creates a new node adds a
// clearing state (ST_CLR) that writes the new node's row to zero.
// Reset: asynchronous, active low; the trie is empty (root only) right after
// reset, no clearing pass. Stalls: the receiver cannot stall; each result is
// shown for exactly one cycle while done is high, and may overlap the next
// transfer on the input side.
`default_nettype none

module trie_prefix_conflict_checker #(
	parameter int MAX_NODES = 1024,
	parameter int RADIX     = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tpcc_pkg::DIGIT_W-1:0] digit,
	input  logic                         last_digit,
	input  logic                         new_list,
	output logic                         busy,
	output logic                         done,
	output logic                         list_conflict,
	output logic                         pool_full,
	output logic                         number_done
);

	import tpcc_pkg::*;

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int DIG_W  = $clog2(RADIX);
	localparam int DGE_W  = DIGIT_W + 1;
	localparam int SLOT_W = IDX_W + 1;
	localparam int ROW_W  = RADIX * SLOT_W;

	// One memory row per node. Each slot holds the child index (0 = none) and
	// the end mark of that child, so the end check needs no second read.
	typedef struct packed {
		logic             ends;
		logic [IDX_W-1:0] child;
	} slot_t;

	typedef slot_t [RADIX-1:0] row_t;

	state_t            state_q;
	logic [IDX_W-1:0]  cur_q;       // node the current number stands on
	logic [CNT_W-1:0]  count_q;     // allocated nodes, root included
	logic              created_q;   // current number made a node
	logic              conflict_q;
	logic              overflow_q;
	logic              stalled_q;   // current number hit a full pool
	logic              fresh_q;     // row of cur_q is logically zero, not yet written
	logic [DIG_W-1:0]  digit_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  clr_q;       // new leaf whose row still needs zeroing
	logic              done_q;
	logic              list_conflict_q;
	logic              pool_full_q;
	logic              number_done_q;

	logic              accept;
	logic [DIG_W-1:0]  digit_sat;
	logic [IDX_W-1:0]  rd_addr;
	logic [ROW_W-1:0]  rd_data;
	row_t              row_rd;
	row_t              row_wr;
	slot_t             slot_cur;
	logic              has_room;
	logic [IDX_W-1:0]  new_idx;
	logic              walk;
	logic              alloc;
	logic              stall_now;
	logic              stalled_nx;
	logic              created_nx;
	logic              conflict_nx;
	logic              overflow_nx;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [ROW_W-1:0]  wdata;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Digits past the radix saturate to the top digit.
	assign digit_sat = (DGE_W'(digit) >= DGE_W'(RADIX)) ? DIG_W'(RADIX - 1)
	                                                    : digit[DIG_W-1:0];

	// A new list restarts at the root, so the read goes there directly.
	assign rd_addr = new_list ? '0 : cur_q;

	tpcc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_NODES)
	) u_rows (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Execute stage: pick the slot, decide walk / allocate / overflow.
	always_comb begin
		row_rd    = fresh_q ? '0 : row_t'(rd_data);
		slot_cur  = row_rd[digit_s1];
		has_room  = (count_q != CNT_W'(MAX_NODES));
		new_idx   = count_q[IDX_W-1:0];
		walk      = !stalled_q && (slot_cur.child != '0);
		alloc     = !stalled_q && (slot_cur.child == '0) && has_room;
		stall_now = !stalled_q && (slot_cur.child == '0) && !has_room;

		row_wr = row_rd;
		if (alloc) begin
			row_wr[digit_s1].ends  = last_s1;
			row_wr[digit_s1].child = new_idx;
		end else if (walk) begin
			row_wr[digit_s1].ends = slot_cur.ends | last_s1;
		end

		stalled_nx  = stalled_q | stall_now;
		created_nx  = created_q | alloc;
		overflow_nx = overflow_q | stall_now;
		conflict_nx = conflict_q | (walk && slot_cur.ends)
		            | (last_s1 && !stalled_nx && !created_nx);
	end

	// Write-back: the row of the current node after an allocation, an end mark
	// or a first overflow on a row never written; in ST_CLR the new leaf's row.
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = row_wr;
		case (state_q)
			ST_EXEC: begin
				we = alloc || (walk && last_s1) || (stall_now && fresh_q);
			end
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cur_q           <= '0;
			count_q         <= CNT_W'(1);
			created_q       <= 1'b0;
			conflict_q      <= 1'b0;
			overflow_q      <= 1'b0;
			stalled_q       <= 1'b0;
			fresh_q         <= 1'b1;
			done_q          <= 1'b0;
			list_conflict_q <= 1'b0;
			pool_full_q     <= 1'b0;
			number_done_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= ST_EXEC;
						if (new_list) begin
							cur_q      <= '0;
							count_q    <= CNT_W'(1);
							created_q  <= 1'b0;
							conflict_q <= 1'b0;
							overflow_q <= 1'b0;
							stalled_q  <= 1'b0;
							fresh_q    <= 1'b1;
						end
					end
				end
				ST_EXEC: begin
					if (alloc) begin
						count_q <= count_q + CNT_W'(1);
					end
					conflict_q <= conflict_nx;
					overflow_q <= overflow_nx;
					if (last_s1) begin
						// root row is written by the first digit of each list, so it is no longer fresh
						cur_q     <= '0;
						created_q <= 1'b0;
						stalled_q <= 1'b0;
						fresh_q   <= 1'b0;
					end else begin
						cur_q     <= alloc ? new_idx : (walk ? slot_cur.child : cur_q);
						created_q <= created_nx;
						stalled_q <= stalled_nx;
						fresh_q   <= alloc || (fresh_q && !walk && !stall_now);
					end
					done_q          <= 1'b1;
					list_conflict_q <= conflict_nx;
					pool_full_q     <= overflow_nx;
					number_done_q   <= last_s1;
					state_q         <= (alloc && last_s1) ? ST_CLR : ST_IDLE;
				end
				ST_CLR: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and pending-clear registers, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			digit_s1 <= digit_sat;
			last_s1  <= last_digit;
		end
		if (state_q == ST_EXEC) begin
			clr_q <= new_idx;
		end
	end

	assign done          = done_q;
	assign list_conflict = list_conflict_q;
	assign pool_full     = pool_full_q;
	assign number_done   = number_done_q;

endmodule

`default_nettype wire

[rtl/tpcc_checker.sv]
// Port-level assertions for the trie prefix conflict checker, and its bind.
// Depends on trie_prefix_conflict_checker_macros.svh.
`default_nettype none
`include "trie_prefix_conflict_checker_macros.svh"

module tpcc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic list_conflict,
	input wire logic pool_full,
	input wire logic number_done
);

	// a transfer makes the block busy for the execute cycle
	`TPCC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after transfer")

	// every transfer yields its result once the execute state has passed
	`TPCC_ASSERT_NXT(a_accept_done, start && !busy, ##1 done, "result missing")

	// a result strobe lasts one cycle
	`TPCC_ASSERT_NXT(a_done_pulse, done, !done, "result strobe too long")

	// busy never lasts beyond the execute state and the clearing state
	`TPCC_ASSERT_NXT(a_busy_bound, busy && $past(busy), !busy, "busy too long")

	// result fields only move together with a strobe
	`TPCC_ASSERT_IMP(a_out_hold, !done,
		$stable({list_conflict, pool_full, number_done}), "result changed without strobe")

endmodule

bind trie_prefix_conflict_checker tpcc_checker u_tpcc_checker (.*);

`default_nettype wire
